@@ design/bmsi_pkg.sv @@
// Shared types, constants and codes for the bitmap set with iterator.
`default_nettype none
package bmsi_pkg;

    localparam int ACTION_W      = 4;
    localparam int MEMBER_W      = 11;
    localparam int WIDX_W        = 4;
    localparam int VALUE_W       = 64;
    localparam int MOUT_W        = 10;
    localparam int WORDS_DEF     = 16;
    localparam int WORD_BITS_DEF = 64;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT  = 4'd0,
        ACT_REMOVE  = 4'd1,
        ACT_TEST    = 4'd2,
        ACT_CLEAR   = 4'd3,
        ACT_FILL    = 4'd4,
        ACT_OR      = 4'd5,
        ACT_AND     = 4'd6,
        ACT_ANDNOT  = 4'd7,
        ACT_RESTART = 4'd8,
        ACT_NEXT    = 4'd9,
        ACT_EMPTY   = 4'd10
    } action_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_SPLIT,
        ST_FIX,
        ST_READ,
        ST_MODIFY,
        ST_SWEEP,
        ST_SCAN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic accept;
        logic init;
        logic split;
        logic fix;
        logic read;
        logic modify;
        logic sweep;
        logic scan;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic scan_end;
        logic out_free;
    } dp_status_t;

endpackage
`default_nettype wire

@@ design/bmsi_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module bmsi_ram #(
    parameter int WIDTH = bmsi_pkg::WORD_BITS_DEF,
    parameter int DEPTH = bmsi_pkg::WORDS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ design/bmsi_ctrl.sv @@
// Controller state machine sequencing each item through the datapath.
`default_nettype none
module bmsi_ctrl (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic [bmsi_pkg::ACTION_W-1:0] action,
    input  wire bmsi_pkg::dp_status_t       status,
    output logic                            in_ready,
    output bmsi_pkg::ctrl_cmd_t             cmd
);
    import bmsi_pkg::*;

    state_t  state_reg;
    state_t  state_next;
    action_t act;

    assign act = action_t'(action);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (act)
                        ACT_INSERT, ACT_REMOVE, ACT_TEST,
                        ACT_OR, ACT_AND, ACT_ANDNOT: state_next = ST_SPLIT;
                        ACT_CLEAR, ACT_FILL:         state_next = ST_SWEEP;
                        ACT_NEXT, ACT_EMPTY:         state_next = ST_SCAN;
                        default:                     state_next = ST_DONE;
                    endcase
                end
            end
            ST_SPLIT:  state_next = ST_FIX;
            ST_FIX:    state_next = ST_READ;
            ST_READ:   state_next = ST_MODIFY;
            ST_MODIFY: state_next = ST_DONE;
            ST_SWEEP:
            begin
                if (status.sweep_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_INIT;
        endcase
    end

    always_comb
    begin
        in_ready     = (state_reg == ST_IDLE);
        cmd          = '0;
        cmd.accept   = (state_reg == ST_IDLE) && in_valid;
        cmd.init     = (state_reg == ST_INIT);
        cmd.split    = (state_reg == ST_SPLIT);
        cmd.fix      = (state_reg == ST_FIX);
        cmd.read     = (state_reg == ST_READ);
        cmd.modify   = (state_reg == ST_MODIFY);
        cmd.sweep    = (state_reg == ST_SWEEP);
        cmd.scan     = (state_reg == ST_SCAN);
        cmd.load_out = (state_reg == ST_DONE) && status.out_free;
    end

`ifndef SYNTHESIS
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> (state_reg != ST_IDLE))
        else $error("accepted item did not leave the idle state");
`endif

endmodule
`default_nettype wire

@@ design/bmsi_dp.sv @@
// Datapath: bitmap memory, member split, word scanner, cursor and result register.
`default_nettype none
module bmsi_dp #(
    parameter int WORDS     = bmsi_pkg::WORDS_DEF,
    parameter int WORD_BITS = bmsi_pkg::WORD_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire bmsi_pkg::ctrl_cmd_t           cmd,
    output bmsi_pkg::dp_status_t               status,
    input  wire logic [bmsi_pkg::ACTION_W-1:0] action,
    input  wire logic [bmsi_pkg::MEMBER_W-1:0] member_index,
    input  wire logic [bmsi_pkg::WIDX_W-1:0]   word_index,
    input  wire logic [bmsi_pkg::VALUE_W-1:0]  word_value,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic                               hit,
    output logic                               found,
    output logic [bmsi_pkg::MOUT_W-1:0]        member_out,
    output logic                               done_res,
    output logic                               empty_res,
    output logic                               out_of_range
);
    import bmsi_pkg::*;

    localparam int CAP   = WORDS * WORD_BITS;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int PW    = $clog2(WORDS + 1);
    localparam int BW    = $clog2(WORD_BITS);
    localparam int CW    = $clog2(CAP + 1);
    localparam int RK    = MEMBER_W + BW;
    localparam int RECIP = (1 << RK) / WORD_BITS;
    localparam int PRODW = MEMBER_W + RK;
    localparam int QW    = MEMBER_W + 1 - BW;

    // Item registers.
    action_t                action_reg;
    logic [MEMBER_W-1:0]    member_reg;
    logic [WIDX_W-1:0]      widx_reg;
    logic [WORD_BITS-1:0]   wval_reg;

    // Member split and addressing.
    logic [QW-1:0]          qest_reg, qest_next;
    logic [AW-1:0]          word_reg, word_next;
    logic [BW-1:0]          bit_reg, bit_next;
    logic                   addr_ok_reg, addr_ok_next;
    logic [PRODW-1:0]       prod;
    logic [MEMBER_W-1:0]    qmul;
    logic [MEMBER_W-1:0]    rem;
    logic                   rem_big;
    logic [QW-1:0]          q_fixed;
    logic                   is_point;

    // Cursor.
    logic [PW-1:0]          cur_word_reg, cur_word_next;
    logic [BW-1:0]          cur_bit_reg, cur_bit_next;
    logic [CW-1:0]          cur_base_reg, cur_base_next;

    // Scanner.
    logic [PW-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]          rd_base_reg, rd_base_next;
    logic [BW-1:0]          lo_first_reg, lo_first_next;
    logic                   pend_reg, pend_next;
    logic [PW-1:0]          chk_ptr_reg, chk_ptr_next;
    logic [CW-1:0]          chk_base_reg, chk_base_next;
    logic [BW-1:0]          chk_lo_reg, chk_lo_next;
    logic                   issue;
    logic                   hit_word;
    logic [WORD_BITS-1:0]   masked;
    logic [BW-1:0]          idx;
    logic [BW:0]            idx_inc;
    logic [CW-1:0]          found_lin;

    // Sweep pointer.
    logic [AW-1:0]          sweep_ptr_reg, sweep_ptr_next;

    // Pending result and output register.
    logic                   res_hit_reg, res_hit_next;
    logic                   res_found_reg, res_found_next;
    logic [MOUT_W-1:0]      res_member_reg, res_member_next;
    logic                   res_done_reg, res_done_next;
    logic                   res_empty_reg, res_empty_next;
    logic                   res_oor_reg, res_oor_next;
    logic                   out_valid_reg, out_valid_next;

    // Memory port.
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [WORD_BITS-1:0]   ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [WORD_BITS-1:0]   ram_rdata;
    logic [WORD_BITS-1:0]   new_word;
    logic                   mod_write;
    logic [WORD_BITS-1:0]   bit_one;

    bmsi_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (WORDS),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign is_point = (action_reg == ACT_INSERT) || (action_reg == ACT_REMOVE) ||
                      (action_reg == ACT_TEST);

    // Member split by reciprocal multiply; the estimate is low by at most one.
    assign prod    = PRODW'(member_reg) * PRODW'(RECIP);
    assign qmul    = MEMBER_W'(qest_reg) * MEMBER_W'(WORD_BITS);
    assign rem     = member_reg - qmul;
    assign rem_big = (rem >= MEMBER_W'(WORD_BITS));
    assign q_fixed = rem_big ? (qest_reg + QW'(1)) : qest_reg;

    // Scanner: lowest set bit of the checked word at or above its lower bound.
    assign issue    = (rd_ptr_reg < PW'(WORDS));
    assign masked   = ram_rdata & ({WORD_BITS{1'b1}} << chk_lo_reg);
    assign hit_word = pend_reg && (|masked);
    assign idx_inc  = {1'b0, idx} + (BW+1)'(1);
    assign found_lin = chk_base_reg + CW'(idx);

    always_comb
    begin
        idx = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (masked[i])
            begin
                idx = BW'(i);
            end
        end
    end

    // Read-modify-write of one word.
    assign bit_one = WORD_BITS'(1) << bit_reg;

    always_comb
    begin
        new_word  = ram_rdata;
        mod_write = 1'b0;
        unique case (action_reg)
            ACT_INSERT:
            begin
                new_word  = ram_rdata | bit_one;
                mod_write = 1'b1;
            end
            ACT_REMOVE:
            begin
                new_word  = ram_rdata & ~bit_one;
                mod_write = 1'b1;
            end
            ACT_OR:
            begin
                new_word  = ram_rdata | wval_reg;
                mod_write = 1'b1;
            end
            ACT_AND:
            begin
                new_word  = ram_rdata & wval_reg;
                mod_write = 1'b1;
            end
            ACT_ANDNOT:
            begin
                new_word  = ram_rdata & ~wval_reg;
                mod_write = 1'b1;
            end
            default:
            begin
                new_word  = ram_rdata;
                mod_write = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = word_reg;
        ram_wdata = new_word;
        if (cmd.init || cmd.sweep)
        begin
            ram_we    = 1'b1;
            ram_waddr = sweep_ptr_reg;
            ram_wdata = (cmd.sweep && (action_reg == ACT_FILL)) ? {WORD_BITS{1'b1}} : '0;
        end
        else if (cmd.modify)
        begin
            ram_we = mod_write && addr_ok_reg;
        end
        ram_raddr = cmd.read ? word_reg : rd_ptr_reg[AW-1:0];
    end

    assign status.sweep_last = (sweep_ptr_reg == AW'(WORDS - 1));
    assign status.scan_end   = hit_word || !issue;
    assign status.out_free   = !out_valid_reg || out_ready;

    always_comb
    begin
        qest_next       = qest_reg;
        word_next       = word_reg;
        bit_next        = bit_reg;
        addr_ok_next    = addr_ok_reg;
        cur_word_next   = cur_word_reg;
        cur_bit_next    = cur_bit_reg;
        cur_base_next   = cur_base_reg;
        rd_ptr_next     = rd_ptr_reg;
        rd_base_next    = rd_base_reg;
        lo_first_next   = lo_first_reg;
        pend_next       = pend_reg;
        chk_ptr_next    = chk_ptr_reg;
        chk_base_next   = chk_base_reg;
        chk_lo_next     = chk_lo_reg;
        sweep_ptr_next  = sweep_ptr_reg;
        res_hit_next    = res_hit_reg;
        res_found_next  = res_found_reg;
        res_member_next = res_member_reg;
        res_done_next   = res_done_reg;
        res_empty_next  = res_empty_reg;
        res_oor_next    = res_oor_reg;
        out_valid_next  = out_valid_reg;

        if (cmd.accept)
        begin
            res_hit_next    = 1'b0;
            res_found_next  = 1'b0;
            res_member_next = '0;
            res_done_next   = 1'b0;
            res_empty_next  = 1'b0;
            res_oor_next    = 1'b0;
            pend_next       = 1'b0;
            sweep_ptr_next  = '0;
            if (action_t'(action) == ACT_NEXT)
            begin
                rd_ptr_next   = cur_word_reg;
                rd_base_next  = cur_base_reg;
                lo_first_next = cur_bit_reg;
            end
            else
            begin
                rd_ptr_next   = '0;
                rd_base_next  = '0;
                lo_first_next = '0;
            end
            if (action_t'(action) == ACT_RESTART)
            begin
                cur_word_next = '0;
                cur_bit_next  = '0;
                cur_base_next = '0;
            end
        end

        if (cmd.split)
        begin
            qest_next = QW'(prod >> RK);
        end

        if (cmd.fix)
        begin
            if (is_point)
            begin
                word_next    = AW'(q_fixed);
                bit_next     = rem_big ? BW'(rem - MEMBER_W'(WORD_BITS)) : BW'(rem);
                addr_ok_next = (32'(member_reg) < 32'(CAP));
            end
            else
            begin
                word_next    = AW'(32'(widx_reg));
                bit_next     = '0;
                addr_ok_next = (32'(widx_reg) < 32'(WORDS));
            end
        end

        if (cmd.modify)
        begin
            res_hit_next = (action_reg == ACT_TEST) && addr_ok_reg && ram_rdata[bit_reg];
            res_oor_next = (action_reg == ACT_INSERT) && !addr_ok_reg;
        end

        if (cmd.init || cmd.sweep)
        begin
            sweep_ptr_next = status.sweep_last ? '0 : (sweep_ptr_reg + AW'(1));
        end

        if (cmd.scan)
        begin
            if (status.scan_end)
            begin
                pend_next = 1'b0;
                if (action_reg == ACT_NEXT)
                begin
                    res_found_next  = hit_word;
                    res_done_next   = !hit_word;
                    res_member_next = hit_word ? MOUT_W'(found_lin) : '0;
                    if (hit_word)
                    begin
                        if (idx_inc == (BW+1)'(WORD_BITS))
                        begin
                            cur_word_next = chk_ptr_reg + PW'(1);
                            cur_bit_next  = '0;
                            cur_base_next = chk_base_reg + CW'(WORD_BITS);
                        end
                        else
                        begin
                            cur_word_next = chk_ptr_reg;
                            cur_bit_next  = idx_inc[BW-1:0];
                            cur_base_next = chk_base_reg;
                        end
                    end
                    else
                    begin
                        cur_word_next = PW'(WORDS);
                        cur_bit_next  = '0;
                        cur_base_next = CW'(CAP);
                    end
                end
                else
                begin
                    res_empty_next = !hit_word;
                end
            end
            else
            begin
                pend_next     = 1'b1;
                chk_ptr_next  = rd_ptr_reg;
                chk_base_next = rd_base_reg;
                chk_lo_next   = lo_first_reg;
                lo_first_next = '0;
                rd_ptr_next   = rd_ptr_reg + PW'(1);
                rd_base_next  = rd_base_reg + CW'(WORD_BITS);
            end
        end

        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_word_reg  <= '0;
            cur_bit_reg   <= '0;
            cur_base_reg  <= '0;
            pend_reg      <= 1'b0;
            sweep_ptr_reg <= '0;
            out_valid_reg <= 1'b0;
            rd_ptr_reg    <= '0;
            rd_base_reg   <= '0;
            lo_first_reg  <= '0;
        end
        else
        begin
            cur_word_reg  <= cur_word_next;
            cur_bit_reg   <= cur_bit_next;
            cur_base_reg  <= cur_base_next;
            pend_reg      <= pend_next;
            sweep_ptr_reg <= sweep_ptr_next;
            out_valid_reg <= out_valid_next;
            rd_ptr_reg    <= rd_ptr_next;
            rd_base_reg   <= rd_base_next;
            lo_first_reg  <= lo_first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            action_reg <= action_t'(action);
            member_reg <= member_index;
            widx_reg   <= word_index;
            wval_reg   <= word_value[WORD_BITS-1:0];
        end
        qest_reg       <= qest_next;
        word_reg       <= word_next;
        bit_reg        <= bit_next;
        addr_ok_reg    <= addr_ok_next;
        chk_ptr_reg    <= chk_ptr_next;
        chk_base_reg   <= chk_base_next;
        chk_lo_reg     <= chk_lo_next;
        res_hit_reg    <= res_hit_next;
        res_found_reg  <= res_found_next;
        res_member_reg <= res_member_next;
        res_done_reg   <= res_done_next;
        res_empty_reg  <= res_empty_next;
        res_oor_reg    <= res_oor_next;
        if (cmd.load_out)
        begin
            hit          <= res_hit_reg;
            found        <= res_found_reg;
            member_out   <= res_member_reg;
            done_res     <= res_done_reg;
            empty_res    <= res_empty_reg;
            out_of_range <= res_oor_reg;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_cursor_base: assert property (@(posedge clk) disable iff (!rst_n)
        cur_base_reg == CW'(cur_word_reg * WORD_BITS))
        else $error("cursor base does not match cursor word");
    a_cursor_end: assert property (@(posedge clk) disable iff (!rst_n)
        (cur_word_reg == PW'(WORDS)) |-> (cur_bit_reg == '0))
        else $error("exhausted cursor has a non-zero bit offset");
    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |-> !ram_we)
        else $error("bitmap written while scanning");
    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> (out_valid_reg && !(found && done_res)))
        else $error("loaded result not shown or found and done both set");
`endif

endmodule
`default_nettype wire

@@ design/bitmap_set_with_iterator_unit.sv @@
// Top level of the bitmap set with a forward iterator.
`default_nettype none
// A fixed-capacity bitmap set of WORDS words of WORD_BITS bits each, member m
// being bit m mod WORD_BITS of word m div WORD_BITS, kept in a single RAM with a
// registered read port. Each item carries one action and produces exactly one
// result item. Items are handled one at a time, but the next item is accepted
// while the previous result still waits in the output register. Restart and the
// unused action codes go straight to the result state; insert, remove, test and
// the three word combines pass through member split by reciprocal multiply and
// correction, RAM read, then write-back; clear and fill have the RAM write port
// sweep one word a cycle; next and the empty query have the scanner read one
// word a cycle from the RAM read port, and it stops at the first word holding
// a qualifying bit. After reset the block zeroes the RAM before it accepts its
// first item. A result wider than the member output keeps only the low ten bits
// of the member found.
module bitmap_set_with_iterator_unit #(
    parameter int WORDS     = bmsi_pkg::WORDS_DEF,
    parameter int WORD_BITS = bmsi_pkg::WORD_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [bmsi_pkg::ACTION_W-1:0] action,
    input  wire logic [bmsi_pkg::MEMBER_W-1:0] member_index,
    input  wire logic [bmsi_pkg::WIDX_W-1:0]   word_index,
    input  wire logic [bmsi_pkg::VALUE_W-1:0]  word_value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               hit,
    output logic                               found,
    output logic [bmsi_pkg::MOUT_W-1:0]        member_out,
    output logic                               done_res,
    output logic                               empty_res,
    output logic                               out_of_range
);
    import bmsi_pkg::*;

    // Commands from the controller and status back from the datapath.
    ctrl_cmd_t  cmd;
    dp_status_t status;

    // The controller decodes the action on the accepting edge and walks the
    // item through split, fix, read, modify, sweep or scan states.
    bmsi_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .action   (action),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    // The datapath holds the bitmap RAM, the iterator cursor, the scanner
    // and the output register.
    bmsi_dp #(
        .WORDS     (WORDS),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .action       (action),
        .member_index (member_index),
        .word_index   (word_index),
        .word_value   (word_value),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .hit          (hit),
        .found        (found),
        .member_out   (member_out),
        .done_res     (done_res),
        .empty_res    (empty_res),
        .out_of_range (out_of_range)
    );

endmodule
`default_nettype wire
